// ===== src/mcsl_pkg.sv =====
// Shared types and constants for the multichannel interval sample logger.
// No dependencies; every other file but mcsl_ram imports this package.
`timescale 1ns / 1ps

package mcsl_pkg;

  localparam int TIME_W       = 64;
  localparam int TS_W         = 32;
  localparam int VAL_W        = 32;
  localparam int CMD_W        = 2;
  localparam int CH_W         = 2;
  localparam int IDX_W        = 8;
  localparam int CNT_OUT_W    = 9;
  localparam int POS_OUT_W    = 8;
  localparam int CFG_CHANNELS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int ENTRY_W      = TS_W + VAL_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CH_ACTIVE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_3  = 3'd5;

  // per-lane strobes from the sequencer
  typedef struct packed {
    logic tick;
    logic clear;
    logic read;
  } lane_cmd_t;

  // what a lane reports back for a read
  typedef struct packed {
    logic                 hit;
    logic [TS_W-1:0]      ts;
    logic [VAL_W-1:0]     value;
    logic [CNT_OUT_W-1:0] count;
    logic [POS_OUT_W-1:0] pos;
  } lane_res_t;

endpackage

// ===== src/mcsl_if.sv =====
// Valid/ready channel interfaces for the logger's command input and read result.
// Depends on mcsl_pkg for field widths.
`timescale 1ns / 1ps

interface mcsl_in_if import mcsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TIME_W-1:0] now_usec;
  logic [VAL_W-1:0]  sample_ch0;
  logic [VAL_W-1:0]  sample_ch1;
  logic [VAL_W-1:0]  sample_ch2;
  logic [VAL_W-1:0]  sample_ch3;
  logic [CH_W-1:0]   channel;
  logic [IDX_W-1:0]  entry_index;

  modport source (
    output valid, cmd, now_usec, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           channel, entry_index,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_usec, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           channel, entry_index,
    output ready
  );
endinterface

interface mcsl_out_if import mcsl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TS_W-1:0]      entry_timestamp;
  logic [VAL_W-1:0]     entry_value;
  logic [CNT_OUT_W-1:0] sample_count;
  logic [POS_OUT_W-1:0] write_position;

  modport source (
    output valid, entry_timestamp, entry_value, sample_count, write_position,
    input  ready
  );
  modport sink (
    input  valid, entry_timestamp, entry_value, sample_count, write_position,
    output ready
  );
endinterface

// ===== src/multichannel_interval_sample_logger_top.sv =====
// Top level of the multichannel interval sample logger: config registers, sequencer, lanes.
// Depends on mcsl_pkg, mcsl_if, mcsl_lane and mcsl_merge.
`timescale 1ns / 1ps

// One transaction is handled at a time. A tick or clear passes through the execute
// state before ready rises again; a read passes through the execute and merge states,
// waiting on the registered read port of the channel's sample memory, and stays in
// merge while the previous result still sits unaccepted in the output register.
// Every channel is a lane with its own ring memory, so all active channels capture
// in the same cycle. There is no clearing pass after reset or on a clear command:
// each lane keeps a fill count, and a slot at or beyond it reads back as zero.
module multichannel_interval_sample_logger_top import mcsl_pkg::*; #(
  parameter int NUM_CHANNELS = 4,
  parameter int SAMPLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  mcsl_in_if.sink               in_ch,
  mcsl_out_if.source            out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_MERGE = 3'b100
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now_usec;
    logic [VAL_W-1:0]  s0;
    logic [VAL_W-1:0]  s1;
    logic [VAL_W-1:0]  s2;
    logic [VAL_W-1:0]  s3;
    logic [CH_W-1:0]   channel;
    logic [IDX_W-1:0]  entry_index;
  } item_t;

  state_t                  state_r, state_nxt;
  item_t                   item_r;
  logic                    run_r;
  logic [CFG_CHANNELS-1:0] active_r;
  logic [TS_W-1:0]         interval_r [CFG_CHANNELS];
  logic                    in_fire;
  logic                    exec;
  logic                    merge_free;
  logic                    out_load;
  logic [VAL_W-1:0]        samples [CFG_CHANNELS];
  lane_res_t               lane_res [CFG_CHANNELS];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      active_r   <= '0;
      interval_r <= '{default: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RUN_ENABLE: run_r         <= cfg_wdata[0];
        REG_CH_ACTIVE:  active_r      <= cfg_wdata[CFG_CHANNELS-1:0];
        REG_INTERVAL_0: interval_r[0] <= cfg_wdata[TS_W-1:0];
        REG_INTERVAL_1: interval_r[1] <= cfg_wdata[TS_W-1:0];
        REG_INTERVAL_2: interval_r[2] <= cfg_wdata[TS_W-1:0];
        REG_INTERVAL_3: interval_r[3] <= cfg_wdata[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign exec        = (state_r == ST_EXEC);
  assign out_load    = (state_r == ST_MERGE) && merge_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = (item_r.cmd == CMD_READ) ? ST_MERGE : ST_IDLE;
      ST_MERGE: if (merge_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.cmd         <= in_ch.cmd;
      item_r.now_usec    <= in_ch.now_usec;
      item_r.s0          <= in_ch.sample_ch0;
      item_r.s1          <= in_ch.sample_ch1;
      item_r.s2          <= in_ch.sample_ch2;
      item_r.s3          <= in_ch.sample_ch3;
      item_r.channel     <= in_ch.channel;
      item_r.entry_index <= in_ch.entry_index;
    end
  end

  assign samples[0] = item_r.s0;
  assign samples[1] = item_r.s1;
  assign samples[2] = item_r.s2;
  assign samples[3] = item_r.s3;

  // lanes; slots for absent channels report zero
  for (genvar g = 0; g < CFG_CHANNELS; g++) begin : g_lane
    if (g < NUM_CHANNELS) begin : g_on
      lane_cmd_t lcmd;

      assign lcmd.tick  = exec && (item_r.cmd == CMD_TICK) && run_r && active_r[g];
      assign lcmd.clear = exec && (item_r.cmd == CMD_CLEAR) && (item_r.channel == CH_W'(g));
      assign lcmd.read  = exec && (item_r.cmd == CMD_READ) && (item_r.channel == CH_W'(g));

      mcsl_lane #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
      ) u_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (lcmd),
        .now_usec    (item_r.now_usec),
        .sample      (samples[g]),
        .interval    (interval_r[g]),
        .entry_index (item_r.entry_index),
        .res         (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  mcsl_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (out_load),
    .channel (item_r.channel),
    .lanes   (lane_res),
    .free    (merge_free),
    .out_ch  (out_ch)
  );

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EXEC)
    else $error("accepted transaction not executed next cycle");

  a_read_to_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && item_r.cmd == CMD_READ) |=> state_r == ST_MERGE)
    else $error("read did not reach merge stage");

endmodule

// ===== src/mcsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mcsl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mcsl_lane.sv =====
// One capture lane: interval check, ring position, fill count and sample memory.
// Depends on mcsl_pkg and mcsl_ram.
`timescale 1ns / 1ps

module mcsl_lane import mcsl_pkg::*; #(
  parameter int SAMPLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lane_cmd_t         cmd,
  input  logic [TIME_W-1:0] now_usec,
  input  logic [VAL_W-1:0]  sample,
  input  logic [TS_W-1:0]   interval,
  input  logic [IDX_W-1:0]  entry_index,
  output lane_res_t         res
);

  localparam int AW   = $clog2(SAMPLE_DEPTH);
  localparam int CW   = $clog2(SAMPLE_DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [TIME_W-1:0]  last_r, last_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               hit_r, hit_nxt;
  logic [TIME_W-1:0]  elapsed;
  logic               due;
  logic [ENTRY_W-1:0] rdata;

  assign elapsed = now_usec - last_r;
  assign due     = cmd.tick && (elapsed >= TIME_W'(interval));

  always_comb begin
    last_nxt  = last_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    hit_nxt   = hit_r;
    if (cmd.clear) begin
      last_nxt  = '0;
      pos_nxt   = '0;
      count_nxt = '0;
    end else if (due) begin
      last_nxt = now_usec;
      pos_nxt  = (pos_r == AW'(SAMPLE_DEPTH - 1)) ? '0 : pos_r + 1'b1;
      if (count_r != CW'(SAMPLE_DEPTH)) begin
        count_nxt = count_r + 1'b1;
      end
    end
    // slots at or beyond the fill count were never written since the last clear
    if (cmd.read) begin
      hit_nxt = CMPW'(entry_index) < CMPW'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      pos_r   <= '0;
      count_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      last_r  <= last_nxt;
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      hit_r   <= hit_nxt;
    end
  end

  mcsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (due),
    .waddr (pos_r),
    .wdata ({sample, now_usec[TS_W-1:0]}),
    .re    (cmd.read),
    .raddr (AW'(entry_index)),
    .rdata (rdata)
  );

  assign res.hit   = hit_r;
  assign res.ts    = rdata[TS_W-1:0];
  assign res.value = rdata[ENTRY_W-1:TS_W];
  assign res.count = CNT_OUT_W'(count_r);
  assign res.pos   = POS_OUT_W'(pos_r);

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SAMPLE_DEPTH))
    else $error("lane fill count above depth");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0 && pos_r == '0 && last_r == '0))
    else $error("lane state not zero after clear");

endmodule

// ===== src/mcsl_merge.sv =====
// Merge stage: picks the addressed lane's read result and holds it in the output register.
// Depends on mcsl_pkg and mcsl_out_if.
`timescale 1ns / 1ps

module mcsl_merge import mcsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic [CH_W-1:0] channel,
  input  lane_res_t lanes [CFG_CHANNELS],
  output logic      free,
  mcsl_out_if.source out_ch
);

  lane_res_t            sel;
  logic                 valid_r, valid_nxt;
  logic [TS_W-1:0]      ts_r;
  logic [VAL_W-1:0]     value_r;
  logic [CNT_OUT_W-1:0] count_r;
  logic [POS_OUT_W-1:0] pos_r;

  // absent lanes are tied to zero, so an out-of-range channel reads all zeros
  assign sel  = lanes[channel];
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ts_r    <= sel.hit ? sel.ts : '0;
      value_r <= sel.hit ? sel.value : '0;
      count_r <= sel.count;
      pos_r   <= sel.pos;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.entry_timestamp = ts_r;
  assign out_ch.entry_value     = value_r;
  assign out_ch.sample_count    = count_r;
  assign out_ch.write_position  = pos_r;

endmodule

// ===== tb/sample_log_watch.sv =====
// Scoreboard for the sample logger: tracks register writes and accepted commands,
// predicts every read result and compares it with the result channel.
// Depends on mcsl_pkg and the channel interfaces in mcsl_if.
`timescale 1ns / 1ps

module sample_log_watch import mcsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  mcsl_in_if                    in_ch,
  mcsl_out_if                   out_ch,
  output int                    mismatches,
  output int                    pending,
  output int                    reads_done,
  output int                    captures
);

  localparam int LANES = 4;
  localparam int DEPTH = 256;

  typedef struct packed {
    logic [TS_W-1:0]      ts;
    logic [VAL_W-1:0]     value;
    logic [CNT_OUT_W-1:0] count;
    logic [POS_OUT_W-1:0] pos;
  } read_reply_t;

  // model of the per-channel rings: time in the low half, value in the high half
  logic [ENTRY_W-1:0]   trace_mem [LANES][DEPTH];
  logic [TIME_W-1:0]    last_cap  [LANES];
  logic [POS_OUT_W-1:0] wr_pos    [LANES];
  logic [CNT_OUT_W-1:0] held      [LANES];
  logic                 run_on;
  logic [LANES-1:0]     lane_on;
  logic [31:0]          min_gap   [LANES];
  read_reply_t          reply_q [$];
  int                   n_err;
  int                   n_reads;
  int                   n_caps;

  function automatic void wipe_lane(input int c);
    for (int i = 0; i < DEPTH; i++) trace_mem[c][i] = '0;
    wr_pos[c]   = '0;
    held[c]     = '0;
    last_cap[c] = '0;
  endfunction

  function automatic void capture_tick(input logic [TIME_W-1:0] now,
                                       input logic [LANES-1:0][VAL_W-1:0] vals);
    for (int c = 0; c < LANES; c++) begin
      // elapsed time is modulo 2^64, so a backwards step looks like a huge gap
      if (lane_on[c] && (now - last_cap[c]) >= {32'd0, min_gap[c]}) begin
        trace_mem[c][wr_pos[c]] = {vals[c], now[TS_W-1:0]};
        last_cap[c] = now;
        wr_pos[c]   = (wr_pos[c] == POS_OUT_W'(DEPTH - 1)) ? '0 : wr_pos[c] + 1'b1;
        if (held[c] < CNT_OUT_W'(DEPTH)) held[c] = held[c] + 1'b1;
        n_caps++;
      end
    end
  endfunction

  function automatic read_reply_t lookup(input logic [CH_W-1:0] c,
                                         input logic [IDX_W-1:0] idx);
    read_reply_t r;
    // at this size every channel and slot the fields can name exists
    r.ts    = trace_mem[c][idx][TS_W-1:0];
    r.value = trace_mem[c][idx][ENTRY_W-1:TS_W];
    r.count = held[c];
    r.pos   = wr_pos[c];
    return r;
  endfunction

  function automatic void compare_reply(input read_reply_t got);
    read_reply_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: read result with none expected: ts=%h value=%h count=%0d pos=%0d",
               $time, got.ts, got.value, got.count, got.pos);
      n_err++;
      return;
    end
    want = reply_q.pop_front();
    n_reads++;
    if (got.ts !== want.ts) begin
      $display("%0t: entry_timestamp expected %h actual %h", $time, want.ts, got.ts);
      n_err++;
    end
    if (got.value !== want.value) begin
      $display("%0t: entry_value expected %h actual %h", $time, want.value, got.value);
      n_err++;
    end
    if (got.count !== want.count) begin
      $display("%0t: sample_count expected %0d actual %0d", $time, want.count, got.count);
      n_err++;
    end
    if (got.pos !== want.pos) begin
      $display("%0t: write_position expected %0d actual %0d", $time, want.pos, got.pos);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      run_on  = 1'b0;
      lane_on = '0;
      for (int c = 0; c < LANES; c++) begin
        min_gap[c] = '0;
        wipe_lane(c);
      end
      reply_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RUN_ENABLE: run_on     = cfg_wdata[0];
          REG_CH_ACTIVE:  lane_on    = cfg_wdata[LANES-1:0];
          REG_INTERVAL_0: min_gap[0] = cfg_wdata;
          REG_INTERVAL_1: min_gap[1] = cfg_wdata;
          REG_INTERVAL_2: min_gap[2] = cfg_wdata;
          REG_INTERVAL_3: min_gap[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready)
        compare_reply({out_ch.entry_timestamp, out_ch.entry_value,
                       out_ch.sample_count, out_ch.write_position});
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.cmd)
          CMD_TICK: begin
            if (run_on)
              capture_tick(in_ch.now_usec, {in_ch.sample_ch3, in_ch.sample_ch2,
                                            in_ch.sample_ch1, in_ch.sample_ch0});
          end
          CMD_CLEAR: wipe_lane(int'(in_ch.channel));
          CMD_READ:  reply_q.push_back(lookup(in_ch.channel, in_ch.entry_index));
          default: ;  // unused code is dropped without a result
        endcase
      end
    end
    mismatches <= n_err;
    pending    <= reply_q.size();
    reads_done <= n_reads;
    captures   <= n_caps;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the sample logger: clock, reset, register writes, command
// stimulus with random gaps and result back-pressure, watchdog and verdict.
// Depends on mcsl_pkg, mcsl_if, the logger top and sample_log_watch.
`timescale 1ns / 1ps

module tb_top;
  import mcsl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int LANES         = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [CMD_W-1:0]             cmd;
    logic [TIME_W-1:0]            now;
    logic [LANES-1:0][VAL_W-1:0]  samples;  // samples[c] goes to channel c
    logic [CH_W-1:0]              ch;
    logic [IDX_W-1:0]             idx;
  } log_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mcsl_in_if  in_ch ();
  mcsl_out_if out_ch ();

  int                mismatches;
  int                pending;
  int                reads_done;
  int                captures;
  logic [TIME_W-1:0] stamp;
  int                step_max;
  bit                quiet;
  int                n_sent;
  int                n_ticks;
  int                n_settings;
  int                ready_hold;
  int                stall_cycles;

  always #4 clk = ~clk;

  multichannel_interval_sample_logger_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sample_log_watch u_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .reads_done (reads_done),
    .captures   (captures)
  );

  // result back-pressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          out_ch.ready <= 1'b1;
          ready_hold   <= $urandom_range(20);
        end
        6, 7, 8: begin
          out_ch.ready <= 1'b0;
          ready_hold   <= $urandom_range(3);
        end
        default: begin
          out_ch.ready <= 1'b0;
          ready_hold   <= $urandom_range(40, 15);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if (quiet) return 0;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
      10, 11, 12, 13, 14, 15, 16:   return $urandom_range(3, 1);
      17, 18:                       return $urandom_range(10, 4);
      default:                      return $urandom_range(40, 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 32'($urandom_range(step_max * 3));
      2:       return $urandom;
      3:       return '1;
      default: return 32'($urandom_range(step_max, 1));
    endcase
  endfunction

  function automatic log_cmd_t cmd_fields(input logic [CMD_W-1:0] cmd,
                                          input logic [TIME_W-1:0] now,
                                          input logic [LANES-1:0][VAL_W-1:0] samples,
                                          input logic [CH_W-1:0] ch,
                                          input logic [IDX_W-1:0] idx);
    log_cmd_t it;
    it.cmd     = cmd;
    it.now     = now;
    it.samples = samples;
    it.ch      = ch;
    it.idx     = idx;
    return it;
  endfunction

  // mostly ticks with a forward-moving clock, reads mixed in, rare clears
  function automatic log_cmd_t rand_item(input bit allow_clear);
    log_cmd_t it;
    int       r;
    it.samples = {$urandom, $urandom, $urandom, $urandom};
    it.ch      = CH_W'($urandom_range(3));
    it.idx     = IDX_W'($urandom_range(255));
    it.now     = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 62) begin
      it.cmd = CMD_TICK;
      case ($urandom_range(33))
        0, 1, 2:  stamp = stamp - TIME_W'($urandom_range(step_max * 2));  // clock steps back
        3, 4:     stamp = stamp + ({$urandom, $urandom} >> $urandom_range(63));
        5:        stamp = {$urandom, $urandom};
        6:        ;  // same time again
        default:  stamp = stamp + TIME_W'($urandom_range(step_max));
      endcase
      it.now = stamp;
    end else if (r < 94 || (r < 97 && !allow_clear)) begin
      it.cmd = CMD_READ;
    end else if (r < 97) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // valid stays high between back-to-back transactions
  task automatic send_item(input log_cmd_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.cmd         <= it.cmd;
    in_ch.now_usec    <= it.now;
    in_ch.sample_ch0  <= it.samples[0];
    in_ch.sample_ch1  <= it.samples[1];
    in_ch.sample_ch2  <= it.samples[2];
    in_ch.sample_ch3  <= it.samples[3];
    in_ch.channel     <= it.ch;
    in_ch.entry_index <= it.idx;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    if (it.cmd == CMD_TICK) n_ticks++;
  endtask

  // ticks and clears give no result, so leave room for one still in flight
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic run, input logic [LANES-1:0] active,
                                input logic [LANES-1:0][31:0] gaps);
    wait_idle();
    write_reg(REG_RUN_ENABLE, CFG_DATA_W'(run));
    write_reg(REG_CH_ACTIVE, CFG_DATA_W'(active));
    write_reg(REG_INTERVAL_0, gaps[0]);
    write_reg(REG_INTERVAL_1, gaps[1]);
    write_reg(REG_INTERVAL_2, gaps[2]);
    write_reg(REG_INTERVAL_3, gaps[3]);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [LANES-1:0][31:0] gaps;
    int                     n_items;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_TICK;
    in_ch.now_usec    = '0;
    in_ch.sample_ch0  = '0;
    in_ch.sample_ch1  = '0;
    in_ch.sample_ch2  = '0;
    in_ch.sample_ch3  = '0;
    in_ch.channel     = '0;
    in_ch.entry_index = '0;
    out_ch.ready      = 1'b0;
    ready_hold        = 0;
    stall_cycles      = 0;
    stamp             = '0;
    step_max          = 10;
    quiet             = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: logger stopped, store reads back empty
    send_item(cmd_fields(CMD_READ, '0, '0, 2'd0, 8'd0));
    send_item(cmd_fields(CMD_TICK, 64'd5, {4{32'h1234_5678}}, 2'd0, 8'd0));
    send_item(cmd_fields(CMD_READ, '0, '0, 2'd0, 8'd0));

    gaps = {32'd0, 32'hFFFF_FFFF, 32'd10, 32'd0};
    apply_settings(1'b1, 4'hF, gaps);
    send_item(cmd_fields(CMD_TICK, 64'd0, {4{32'hFFFF_FFFF}}, 2'd0, 8'd0));
    send_item(cmd_fields(CMD_TICK, '1, {4{32'hA5A5_5A5A}}, 2'd3, 8'd255));
    // time runs backwards: wrapped elapsed time
    send_item(cmd_fields(CMD_TICK, 64'd3, {32'd3, 32'd2, 32'd1, 32'd0}, 2'd0, 8'd0));
    send_item(cmd_fields(CMD_TICK, 64'd3, {4{32'h0F0F_F0F0}}, 2'd0, 8'd0));
    for (int c = 0; c < LANES; c++)
      send_item(cmd_fields(CMD_READ, '1, '1, CH_W'(c), 8'd1));
    send_item(cmd_fields(CMD_READ, '0, '0, 2'd0, 8'd0));
    send_item(cmd_fields(CMD_CLEAR, '1, '1, 2'd1, 8'hFF));
    send_item(cmd_fields(CMD_READ, '0, '0, 2'd1, 8'd0));
    send_item(cmd_fields(CMD_UNUSED, '1, '1, 2'd3, 8'hFF));
    send_item(cmd_fields(CMD_READ, '0, '0, 2'd3, 8'd255));
    send_item(cmd_fields(CMD_TICK, 64'd14, {4{32'h5555_AAAA}}, 2'd0, 8'd0));
    send_item(cmd_fields(CMD_READ, '0, '0, 2'd1, 8'd0));
    send_item(cmd_fields(CMD_READ, '0, '0, 2'd2, 8'd0));
    send_item(cmd_fields(CMD_READ, '0, '0, 2'd3, 8'd3));

    // phase 0 runs long enough for every ring to wrap and saturate
    for (int k = 0; k < 7; k++) begin
      case ($urandom_range(2))
        0:       step_max = 3;
        1:       step_max = 40;
        default: step_max = 1000;
      endcase
      for (int c = 0; c < LANES; c++) gaps[c] = pick_interval();
      n_items = 150;
      case (k)
        0: begin
          step_max = 4;
          n_items  = 480;
          apply_settings(1'b1, 4'hF, '0);
        end
        2: apply_settings(1'b0, 4'hF, '0);
        3: begin
          step_max = 100;
          apply_settings(1'b1, 4'hF, '1);
        end
        default: apply_settings($urandom_range(3) != 0, LANES'($urandom_range(15)), gaps);
      endcase
      for (int i = 0; i < n_items; i++) begin
        if (i % 40 == 0) quiet = ($urandom_range(3) == 0);
        send_item(rand_item(k != 0));
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d commands (%0d ticks) over %0d register settings;", n_sent, n_ticks,
             n_settings);
    $display("compared %0d read results, %0d channel captures modeled", reads_done,
             captures);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
